@@ sv/zssd_pkg.sv @@
// Shared types, codes and sizes for the zero-suppressed sequence decoder.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none
package zssd_pkg;

   // Number of configured hybrid slots (1..7) and the width of one id.
   localparam int HybridSlots = 6;
   localparam int IdWidth     = 7;
   localparam int IdsWidth    = IdWidth * HybridSlots;
   localparam int SlotWidth   = 3;

   localparam int FuncWidth     = 2;
   localparam int SeqWidth      = 16;
   localparam int SampleWidth   = 8;
   localparam int KindWidth     = 2;
   localparam int AnodeWidth    = 8;
   localparam int TimebinWidth  = 10;
   localparam int StartTbWidth  = 9;
   localparam int RunLenWidth   = 5;

   // Sequence word layout.
   localparam int SeqFlagBit   = 15;
   localparam int HybridMsb    = 14;
   localparam int HybridLsb    = 8;
   localparam int StartTbMsb   = 14;
   localparam int StartTbLsb   = 6;
   localparam int LastRunBit   = 5;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_SEQ    = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_BANK   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_SAMPLE  = 2'd0,
      KIND_END     = 2'd1,
      KIND_UNKNOWN = 2'd2,
      KIND_STRAY   = 2'd3
   } kind_type;

   typedef struct packed {
      func_type                func;
      logic [SeqWidth-1:0]     seq_word;
      logic [SampleWidth-1:0]  sample;
   } item_type;

   typedef struct packed {
      kind_type                kind;
      logic [SlotWidth-1:0]    slot;
      logic [AnodeWidth-1:0]   anode;
      logic [TimebinWidth-1:0] timebin;
      logic [SampleWidth-1:0]  sample;
   } result_type;

   typedef struct packed {
      logic                 found;
      logic [SlotWidth-1:0] slot;
   } match_type;

endpackage
`default_nettype wire

@@ sv/zero_suppressed_sequence_decoder_unit.sv @@
// Top level of the zero-suppressed sequence decoder.
// Depends on zssd_pkg and zssd_decode (which holds zssd_slot_match).
//
// The block takes one word per cycle on the req_ channel: a sequence word, an
// ADC sample byte or a bank-start marker, and gives at most one word on the
// rsp_ channel for each. A word passes an input register, then the decode
// logic updates the decode state and loads the result register, so a result
// is offered once its word has passed both registers, and a new word is taken
// every cycle as long as the result register drains. Words that give no
// result still take their slot in the pipe but never stall it. Samples inside
// a run come out tagged with hybrid slot, anode and timebin; a hybrid id of
// zero with no configured match ends the bank, any other unknown id is an
// error, and both halt decoding until the next bank-start. The hybrid id
// register, reset to all zeros, is written over the always-ready csr_
// channel; the user must write it only while the block is idle (not enforced).
`default_nettype none
module zero_suppressed_sequence_decoder_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [zssd_pkg::FuncWidth-1:0]     req_func,
   input  wire logic [zssd_pkg::SeqWidth-1:0]      req_seq_word,
   input  wire logic [zssd_pkg::SampleWidth-1:0]   req_sample_in,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [zssd_pkg::KindWidth-1:0]          rsp_kind,
   output logic [zssd_pkg::SlotWidth-1:0]          rsp_hybrid_slot,
   output logic [zssd_pkg::AnodeWidth-1:0]         rsp_anode,
   output logic [zssd_pkg::TimebinWidth-1:0]       rsp_timebin,
   output logic [zssd_pkg::SampleWidth-1:0]        rsp_sample_out,

   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [zssd_pkg::IdsWidth-1:0]      csr_hybrid_ids
);

   // Hybrid id register.
   logic [zssd_pkg::IdsWidth-1:0] hybrid_ids_ff;

   // Input register stage.
   logic               in_valid_ff;
   zssd_pkg::item_type in_item_ff;
   zssd_pkg::item_type req_item;

   // Result register stage.
   logic                 out_valid_ff, out_valid_in;
   zssd_pkg::result_type out_result_ff;

   logic                 out_free;
   logic                 advance;
   logic                 has_result;
   zssd_pkg::result_type result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hybrid_ids_ff <= '0;
      end else if (csr_valid) begin
         hybrid_ids_ff <= csr_hybrid_ids;
      end
   end

   // Result register frees when empty or being taken this cycle.
   assign out_free  = !out_valid_ff || rsp_ready;
   // Move the held word through decode whenever the result side has room.
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign req_item.func     = zssd_pkg::func_type'(req_func);
   assign req_item.seq_word = req_seq_word;
   assign req_item.sample   = req_sample_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // Payload holds while the stage waits; no reset needed.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   zssd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_item_ff),
      .hybrid_ids (hybrid_ids_ff),
      .has_result (has_result),
      .result     (result)
   );

   // Load a new result when there is room; drop the valid once taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = advance && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_result_ff.kind;
   assign rsp_hybrid_slot = out_result_ff.slot;
   assign rsp_anode       = out_result_ff.anode;
   assign rsp_timebin     = out_result_ff.timebin;
   assign rsp_sample_out  = out_result_ff.sample;

endmodule
`default_nettype wire

@@ sv/zssd_slot_match.sv @@
// Hybrid id lookup: compares one id against the configured slot ids.
// Depends on zssd_pkg.
`default_nettype none
module zssd_slot_match (
   input  wire logic [zssd_pkg::IdsWidth-1:0] hybrid_ids,
   input  wire logic [zssd_pkg::IdWidth-1:0]  hybrid_id,
   output zssd_pkg::match_type                match
);

   logic [zssd_pkg::HybridSlots-1:0] hit;

   always_comb begin
      for (int k = 0; k < zssd_pkg::HybridSlots; k++) begin
         hit[k] = (hybrid_ids[k*zssd_pkg::IdWidth +: zssd_pkg::IdWidth] == hybrid_id);
      end
   end

   // Lowest matching slot wins; slot numbers are one-based.
   always_comb begin
      match.found = 1'b0;
      match.slot  = '0;
      for (int k = zssd_pkg::HybridSlots - 1; k >= 0; k--) begin
         if (hit[k]) begin
            match.found = 1'b1;
            match.slot  = zssd_pkg::SlotWidth'(k + 1);
         end
      end
   end

endmodule
`default_nettype wire

@@ sv/zssd_decode.sv @@
// Decode state and per-word decode logic of the sequence decoder.
// Depends on zssd_pkg and zssd_slot_match.
`default_nettype none
module zssd_decode (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire zssd_pkg::item_type            item,
   input  wire logic [zssd_pkg::IdsWidth-1:0] hybrid_ids,
   output logic                               has_result,
   output zssd_pkg::result_type               result
);

   logic [zssd_pkg::SlotWidth-1:0]    cur_slot_ff, cur_slot_in;
   logic [zssd_pkg::AnodeWidth-1:0]   next_anode_ff, next_anode_in;
   logic [zssd_pkg::AnodeWidth-1:0]   seq_anode_ff, seq_anode_in;
   logic [zssd_pkg::TimebinWidth-1:0] next_timebin_ff, next_timebin_in;
   logic [zssd_pkg::RunLenWidth-1:0]  samples_left_ff, samples_left_in;
   logic                              halted_ff, halted_in;

   logic [zssd_pkg::IdWidth-1:0] hybrid_id;
   zssd_pkg::match_type          match;

   assign hybrid_id = item.seq_word[zssd_pkg::HybridMsb:zssd_pkg::HybridLsb];

   zssd_slot_match u_match (
      .hybrid_ids (hybrid_ids),
      .hybrid_id  (hybrid_id),
      .match      (match)
   );

   always_comb begin
      cur_slot_in     = cur_slot_ff;
      next_anode_in   = next_anode_ff;
      seq_anode_in    = seq_anode_ff;
      next_timebin_in = next_timebin_ff;
      samples_left_in = samples_left_ff;
      halted_in       = halted_ff;
      has_result      = 1'b0;
      result          = '0;
      if (step) begin
         case (item.func)
            zssd_pkg::FUNC_BANK: begin
               cur_slot_in     = '0;
               next_anode_in   = '0;
               seq_anode_in    = '0;
               next_timebin_in = '0;
               samples_left_in = '0;
               halted_in       = 1'b0;
            end
            zssd_pkg::FUNC_SEQ: begin
               if (!halted_ff) begin
                  samples_left_in = '0;
                  if (item.seq_word[zssd_pkg::SeqFlagBit]) begin
                     if (!match.found) begin
                        halted_in   = 1'b1;
                        has_result  = 1'b1;
                        result.kind = (hybrid_id == '0) ? zssd_pkg::KIND_END
                                                        : zssd_pkg::KIND_UNKNOWN;
                     end else begin
                        cur_slot_in   = match.slot;
                        next_anode_in = item.seq_word[zssd_pkg::AnodeWidth-1:0];
                     end
                  end else begin
                     seq_anode_in    = next_anode_ff;
                     next_timebin_in = zssd_pkg::TimebinWidth'(
                        item.seq_word[zssd_pkg::StartTbMsb:zssd_pkg::StartTbLsb]);
                     samples_left_in = item.seq_word[zssd_pkg::RunLenWidth-1:0];
                     if (item.seq_word[zssd_pkg::LastRunBit]) begin
                        next_anode_in = next_anode_ff + 1'b1;
                     end
                  end
               end
            end
            zssd_pkg::FUNC_SAMPLE: begin
               if (!halted_ff) begin
                  has_result    = 1'b1;
                  result.sample = item.sample;
                  if (samples_left_ff == '0) begin
                     result.kind = zssd_pkg::KIND_STRAY;
                  end else begin
                     result.kind     = zssd_pkg::KIND_SAMPLE;
                     result.slot     = cur_slot_ff;
                     result.anode    = seq_anode_ff;
                     result.timebin  = next_timebin_ff;
                     next_timebin_in = next_timebin_ff + 1'b1;
                     samples_left_in = samples_left_ff - 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_slot_ff     <= '0;
         next_anode_ff   <= '0;
         seq_anode_ff    <= '0;
         next_timebin_ff <= '0;
         samples_left_ff <= '0;
         halted_ff       <= 1'b0;
      end else begin
         cur_slot_ff     <= cur_slot_in;
         next_anode_ff   <= next_anode_in;
         seq_anode_ff    <= seq_anode_in;
         next_timebin_ff <= next_timebin_in;
         samples_left_ff <= samples_left_in;
         halted_ff       <= halted_in;
      end
   end

endmodule
`default_nettype wire
